// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL. Synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons must hold as well.
`define ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the next cycle.
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons, msg)
`define ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg)

`endif

`endif

// File: rtl/rgb2hsv_pkg.sv
`timescale 1ns / 1ps

package rgb2hsv_pkg;

  localparam int CHAN_W             = 8;
  localparam int HUE_W              = 13;
  localparam int HUE_FRAC_BITS_DEF  = 4;
  localparam int DEG_PER_SECTOR     = 60;
  localparam int SECTORS            = 6;
  localparam int SAT_FULL           = 255;
  // Position along the hue circle in units of d per sector, below 6 * 255.
  localparam int SECT_POS_W         = 11;

  localparam int S_TDATA_W          = 3 * CHAN_W;
  localparam int M_TDATA_W          = 32;
  localparam int M_TUSER_W          = 1;
  localparam int M_PAD_W            = M_TDATA_W - HUE_W - 2 * CHAN_W;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } sector_t;

  // One restoring division step on an 8-bit divisor. The partial remainder
  // is always below the divisor, so the new remainder fits in CHAN_W bits.
  // Returns {quotient bit, new remainder}.
  function automatic logic [CHAN_W:0] div_step(input logic [CHAN_W-1:0] rem,
                                               input logic              nbit,
                                               input logic [CHAN_W-1:0] divisor);
    logic [CHAN_W:0] x;
    logic [CHAN_W:0] diff;
    x    = {rem, nbit};
    diff = x - {1'b0, divisor};
    if (x >= {1'b0, divisor}) begin
      return {1'b1, diff[CHAN_W-1:0]};
    end else begin
      return {1'b0, x[CHAN_W-1:0]};
    end
  endfunction

endpackage

// File: rtl/rgb_to_hsv_pixel_converter_top.sv
// Channel   Dir  Payload                                            Sideband
// --------  ---  -------------------------------------------------  ---------------
// s_*       in   tdata: red[7:0], green[15:8], blue[23:16]          none
// m_*       out  tdata: hue[12:0], saturation[20:13],               tuser[0]:
//                brightness[28:21], zero[31:29]                     hue_undefined
//
// Throughput is one pixel request per clock while the skid register is empty.
// QH = clog2(6 * 60 * 2^HUE_FRACTION_BITS) is the number of hue quotient bits;
// the divider pipeline after stages A, B and C takes one quotient bit per stage.
// Reset (rst, synchronous, active high) clears every valid bit and the skid.
// A stall on the output freezes the pipeline in the cycle after it; the skid register
// keeps the request that was already on its way, so nothing is lost or repeated.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_to_hsv_pixel_converter_top
  import rgb2hsv_pkg::*;
#(
  parameter int HUE_FRACTION_BITS = HUE_FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // red, green, blue (8 bits each, lowest first)
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // hue (13), saturation (8), brightness (8), zero pad
  output logic [M_TUSER_W-1:0] m_tuser    // hue_undefined
);

  // Hue is floor(t * HUE_SCALE / d), with t in [0, 6d). The quotient stays
  // below 6 * HUE_SCALE, which needs QH bits.
  localparam int HUE_SCALE = DEG_PER_SECTOR << HUE_FRACTION_BITS;
  localparam int QH        = $clog2(SECTORS * HUE_SCALE);
  localparam int NH_W      = CHAN_W + QH;
  // Saturation needs CHAN_W quotient bits; they are taken in the last stages.
  localparam int SAT_STEP0 = QH - CHAN_W;

  // The pipeline advances whenever the skid register is empty. Since that is
  // a register, the input ready never depends on the output ready.
  logic skid_valid;
  logic en;

  assign en       = !skid_valid;
  assign s_tready = !skid_valid;

  // ---------------------------------------------------------------------
  // Stage A: largest and smallest component, and which one is largest.
  // Red wins every tie, then green.
  // ---------------------------------------------------------------------
  logic [CHAN_W-1:0] r_in, g_in, b_in;
  logic [CHAN_W-1:0] hi_next, lo_next;
  sector_t           sect_next;

  assign r_in = s_tdata[CHAN_W-1:0];
  assign g_in = s_tdata[2*CHAN_W-1:CHAN_W];
  assign b_in = s_tdata[3*CHAN_W-1:2*CHAN_W];

  always_comb begin
    if (r_in >= g_in && r_in >= b_in) begin
      sect_next = SECT_RED;
      hi_next   = r_in;
    end else if (g_in >= b_in) begin
      sect_next = SECT_GREEN;
      hi_next   = g_in;
    end else begin
      sect_next = SECT_BLUE;
      hi_next   = b_in;
    end
    lo_next = r_in;
    if (g_in < lo_next) begin
      lo_next = g_in;
    end
    if (b_in < lo_next) begin
      lo_next = b_in;
    end
  end

  logic              va;
  logic [CHAN_W-1:0] r_a, g_a, b_a, hi_a, lo_a;
  sector_t           sect_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_a    <= r_in;
      g_a    <= g_in;
      b_a    <= b_in;
      hi_a   <= hi_next;
      lo_a   <= lo_next;
      sect_a <= sect_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: spread d and position t along the hue circle. A negative red
  // sector hue wraps by a full turn, which is 6d in these units.
  // ---------------------------------------------------------------------
  logic [CHAN_W-1:0]     d_next;
  logic [SECT_POS_W-1:0] d_e, r_e, g_e, b_e;
  logic [SECT_POS_W-1:0] t_next;

  assign d_next = hi_a - lo_a;
  assign d_e    = SECT_POS_W'(d_next);
  assign r_e    = SECT_POS_W'(r_a);
  assign g_e    = SECT_POS_W'(g_a);
  assign b_e    = SECT_POS_W'(b_a);

  always_comb begin
    case (sect_a)
      SECT_RED: begin
        if (g_a >= b_a) begin
          t_next = g_e - b_e;
        end else begin
          t_next = (d_e << 2) + (d_e << 1) + g_e - b_e;
        end
      end
      SECT_GREEN: begin
        t_next = (d_e << 1) + b_e - r_e;
      end
      SECT_BLUE: begin
        t_next = (d_e << 2) + r_e - g_e;
      end
      default: begin
        t_next = '0;
      end
    endcase
  end

  logic                  vb;
  logic [CHAN_W-1:0]     hi_b, d_b;
  logic [SECT_POS_W-1:0] t_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hi_b <= hi_a;
      d_b  <= d_next;
      t_b  <= t_next;
    end
  end

  // ---------------------------------------------------------------------
  // Stage C: dividends for both divisions. Its registers are entry zero of
  // the divider arrays below.
  // ---------------------------------------------------------------------
  logic [NH_W-1:0]     nh_next;
  logic [2*CHAN_W-1:0] ns_next;

  assign nh_next = NH_W'(t_b) * NH_W'(HUE_SCALE);
  assign ns_next = (2*CHAN_W)'(d_b) * (2*CHAN_W)'(SAT_FULL);

  // Entry k holds a request after k division steps.
  logic              dv    [0:QH];
  logic              dgrey [0:QH];
  logic [CHAN_W-1:0] dhi   [0:QH];
  logic [CHAN_W-1:0] dd    [0:QH];
  logic [CHAN_W-1:0] hrem  [0:QH];
  logic [QH-1:0]     hq    [0:QH];
  logic [CHAN_W-1:0] srem  [0:QH];
  logic [CHAN_W-1:0] sq    [0:QH];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= vb;
    end
  end

  // The upper part of each dividend is already below its divisor, so only
  // the lower QH (hue) or CHAN_W (saturation) bits need a step each.
  always_ff @(posedge clk) begin
    if (en) begin
      dgrey[0] <= (d_b == '0);
      dhi[0]   <= hi_b;
      dd[0]    <= d_b;
      hrem[0]  <= nh_next[NH_W-1:QH];
      hq[0]    <= nh_next[QH-1:0];
      srem[0]  <= ns_next[2*CHAN_W-1:CHAN_W];
      sq[0]    <= ns_next[CHAN_W-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Divider pipeline: one quotient bit per stage. Dividend bits leave the
  // top of hq/sq while quotient bits enter at the bottom. Grey and black
  // pixels divide by zero here; their results are replaced at the output.
  // ---------------------------------------------------------------------
  for (genvar k = 0; k < QH; k++) begin : g_div
    logic [CHAN_W:0] hstep;

    assign hstep = div_step(hrem[k], hq[k][QH-1], dd[k]);

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dgrey[k+1] <= dgrey[k];
        dhi[k+1]   <= dhi[k];
        dd[k+1]    <= dd[k];
        hrem[k+1]  <= hstep[CHAN_W-1:0];
        hq[k+1]    <= {hq[k][QH-2:0], hstep[CHAN_W]};
      end
    end

    if (k >= SAT_STEP0) begin : g_sat
      logic [CHAN_W:0] sstep;

      assign sstep = div_step(srem[k], sq[k][CHAN_W-1], dhi[k]);

      always_ff @(posedge clk) begin
        if (en) begin
          srem[k+1] <= sstep[CHAN_W-1:0];
          sq[k+1]   <= {sq[k][CHAN_W-2:0], sstep[CHAN_W]};
        end
      end
    end else begin : g_sat_hold
      always_ff @(posedge clk) begin
        if (en) begin
          srem[k+1] <= srem[k];
          sq[k+1]   <= sq[k];
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Output: the last divider entry is the output register. Hue and
  // saturation are zero when the pixel is black or grey; the hue is cut to
  // its field width.
  // ---------------------------------------------------------------------
  logic [HUE_W-1:0]     hue_o;
  logic [CHAN_W-1:0]    sat_o;
  logic [M_TDATA_W-1:0] ob_tdata;
  logic [M_TUSER_W-1:0] ob_tuser;

  assign hue_o    = dgrey[QH] ? '0 : HUE_W'(hq[QH]);
  assign sat_o    = dgrey[QH] ? '0 : sq[QH];
  assign ob_tdata = {{M_PAD_W{1'b0}}, dhi[QH], sat_o, hue_o};
  assign ob_tuser = M_TUSER_W'(dgrey[QH]);

  // Skid register: when the consumer stalls, the request in the output
  // register moves here while the pipeline shifts once more; then the
  // pipeline holds until the skid drains. The skid is always the older one.
  logic [M_TDATA_W-1:0] skid_tdata;
  logic [M_TUSER_W-1:0] skid_tuser;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (m_tready) begin
        skid_valid <= 1'b0;
      end
    end else if (dv[QH] && !m_tready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      skid_tdata <= ob_tdata;
      skid_tuser <= ob_tuser;
    end
  end

  assign m_tvalid = skid_valid || dv[QH];
  assign m_tdata  = skid_valid ? skid_tdata : ob_tdata;
  assign m_tuser  = skid_valid ? skid_tuser : ob_tuser;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `ASSERT_NEXT(a_accept_enters, clk, rst, s_tvalid && s_tready, va, "accepted pixel did not enter stage A")
  `ASSERT_NEXT(a_skid_holds, clk, rst, skid_valid && !m_tready, skid_valid, "stalled skid request was dropped")
  `ASSERT_IMPL(a_grey_zero, clk, rst, m_tvalid && m_tuser[0], m_tdata[HUE_W+CHAN_W-1:0] == '0, "undefined hue with nonzero hue or saturation")
  `ASSERT_IMPL(a_sat_nonzero, clk, rst, m_tvalid && !m_tuser[0], m_tdata[HUE_W+CHAN_W-1:HUE_W] != '0, "colored pixel with zero saturation")
  `ASSERT_IMPL(a_hue_range, clk, rst, dv[QH] && !dgrey[QH], hq[QH] < QH'(SECTORS * HUE_SCALE), "hue quotient beyond a full turn")

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

// Self-checking bench for the RGB to HSV pixel converter. Pixel requests go in
// on the s_* stream and HSV results come back on the m_* stream. A monitor
// predicts the HSV triple for every accepted pixel and compares each returned
// result, field by field, with the oldest prediction still waiting. The sender
// works in random bursts. The receiver stalls on a rotating pattern, and once
// it holds off long enough that the pipeline fills and stops taking input.
module tb_top;
  import rgb2hsv_pkg::*;

  // Hue offsets, in sectors, of the green and blue thirds of the hue circle.
  localparam int GREEN_BASE     = 2;
  localparam int BLUE_BASE      = 4;
  // One divider stage per hue quotient bit, plus stages A, B and C.
  localparam int HUE_QUOT_BITS  =
    $clog2(SECTORS * DEG_PER_SECTOR * (1 << HUE_FRAC_BITS_DEF));
  localparam int PIPE_LATENCY   = HUE_QUOT_BITS + 3;
  localparam int DRAIN_CYCLES   = 4 * PIPE_LATENCY;
  localparam int HOLD_CYCLES    = 8 * PIPE_LATENCY;
  localparam int RESET_CYCLES   = 9;
  localparam int LIMIT_CYCLES   = 200000;
  localparam int MAX_REPORTS    = 30;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] saturation;
    logic [CHAN_W-1:0] brightness;
    logic              hue_undefined;
  } hsv_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;   // red, green, blue (lowest first)
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;        // hue, saturation, brightness, zero pad
  logic [M_TUSER_W-1:0] m_tuser;        // hue_undefined

  // Predicted results, oldest first.
  hsv_t pending_hsv[$];

  int unsigned mismatches      = 0;
  int unsigned pixels_accepted = 0;
  int unsigned results_checked = 0;
  int unsigned grey_pixels     = 0;
  int unsigned tied_pixels     = 0;
  int unsigned wrapped_hues    = 0;
  int unsigned input_stalls    = 0;
  int unsigned cycle_count     = 0;

  // Sender pacing: requests in bursts; a random gap follows most, none when steady.
  int unsigned burst_left    = 0;
  logic        sender_steady = 1'b0;

  // Receiver pacing: a long hold is asked for by setting hold_request.
  logic        hold_request = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned rx_phase     = 0;

  rgb_to_hsv_pixel_converter_top #(
    .HUE_FRACTION_BITS(HUE_FRAC_BITS_DEF)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Exact HSV for one pixel. The hue position is kept in units of d per
  // sector, so the only rounding is the final floor of the division.
  function automatic hsv_t predict_hsv(input logic [CHAN_W-1:0] r,
                                       input logic [CHAN_W-1:0] g,
                                       input logic [CHAN_W-1:0] b);
    int      rv, gv, bv, hi, lo, d, pos, full;
    sector_t sector;
    hsv_t    res;
    rv = int'(r);
    gv = int'(g);
    bv = int'(b);
    hi = rv;
    if (gv > hi) hi = gv;
    if (bv > hi) hi = bv;
    lo = rv;
    if (gv < lo) lo = gv;
    if (bv < lo) lo = bv;
    d = hi - lo;
    res.brightness = hi[CHAN_W-1:0];
    if (d == 0) begin
      // Black or grey: no hue, and no division at all.
      res.hue           = '0;
      res.saturation    = '0;
      res.hue_undefined = 1'b1;
      return res;
    end
    res.saturation    = CHAN_W'((SAT_FULL * d) / hi);
    res.hue_undefined = 1'b0;
    // Red wins every tie for the maximum, then green.
    if (rv == hi) begin
      sector = SECT_RED;
    end else if (gv == hi) begin
      sector = SECT_GREEN;
    end else begin
      sector = SECT_BLUE;
    end
    case (sector)
      SECT_RED: begin
        // A negative hue wraps around by a full circle.
        pos = (gv >= bv) ? gv - bv : SECTORS * d - (bv - gv);
      end
      SECT_GREEN: begin
        pos = GREEN_BASE * d + bv - rv;
      end
      default: begin
        pos = BLUE_BASE * d + rv - gv;
      end
    endcase
    full    = ((pos * DEG_PER_SECTOR) << HUE_FRAC_BITS_DEF) / d;
    res.hue = HUE_W'(full);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("[%0t] %s on result %0d: got %0d, expected %0d",
               $time, what, results_checked, got, want);
    end
  endtask

  // Input side: every accepted pixel gets its prediction queued here.
  // Output side: every accepted result is checked against the oldest one.
  always @(posedge clk) begin
    hsv_t        want;
    hsv_t        got;
    logic [7:0]  r, g, b;
    if (!rst) begin
      if (s_tvalid && !s_tready) begin
        input_stalls++;
      end
      if (s_tvalid && s_tready) begin
        r    = s_tdata[0 +: CHAN_W];
        g    = s_tdata[CHAN_W +: CHAN_W];
        b    = s_tdata[2 * CHAN_W +: CHAN_W];
        want = predict_hsv(r, g, b);
        pending_hsv.push_back(want);
        pixels_accepted++;
        if (want.hue_undefined) begin
          grey_pixels++;
        end else if (r == want.brightness && b > g) begin
          wrapped_hues++;
        end
        if (!want.hue_undefined &&
            ((r == g && r == want.brightness) || (r == b && r == want.brightness) ||
             (g == b && g == want.brightness))) begin
          tied_pixels++;
        end
      end
      if (m_tvalid && m_tready) begin
        got.hue           = m_tdata[0 +: HUE_W];
        got.saturation    = m_tdata[HUE_W +: CHAN_W];
        got.brightness    = m_tdata[HUE_W + CHAN_W +: CHAN_W];
        got.hue_undefined = m_tuser[0];
        if (pending_hsv.size() == 0) begin
          report_mismatch("result with no pixel pending", 32'(got.hue), 0);
        end else begin
          want = pending_hsv.pop_front();
          if (got.hue != want.hue) begin
            report_mismatch("hue", 32'(got.hue), 32'(want.hue));
          end
          if (got.saturation != want.saturation) begin
            report_mismatch("saturation", 32'(got.saturation), 32'(want.saturation));
          end
          if (got.brightness != want.brightness) begin
            report_mismatch("brightness", 32'(got.brightness), 32'(want.brightness));
          end
          if (got.hue_undefined != want.hue_undefined) begin
            report_mismatch("hue_undefined", 32'(got.hue_undefined),
                            32'(want.hue_undefined));
          end
          if (m_tdata[M_TDATA_W-1 -: M_PAD_W] != '0) begin
            report_mismatch("tdata padding", 32'(m_tdata[M_TDATA_W-1 -: M_PAD_W]), 0);
          end
        end
        results_checked++;
      end
    end
  end

  // Receiver: a rotating stall pattern, unless a long hold was asked for.
  always @(negedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    rx_phase++;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case ((rx_phase / 64) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 9) < 7);
        2: m_tready <= (rx_phase % 3 == 0);
        default: m_tready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_hsv.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offers one pixel request and returns once it is accepted. Valid stays high
  // afterwards, so the next call must come right away or the caller must lower
  // valid at the next falling edge, as wait_drained does.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      if (!sender_steady && $urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 6);
      end
    end
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, g, r};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stops offering and waits for every predicted result to come back.
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_hsv.size() != 0) @(negedge clk);
  endtask

  // Black, white and a few greys: all must flag the hue as undefined.
  task automatic test_grey_and_black();
    send_pixel(8'h00, 8'h00, 8'h00);
    send_pixel(8'hff, 8'hff, 8'hff);
    send_pixel(8'h01, 8'h01, 8'h01);
    send_pixel(8'h80, 8'h80, 8'h80);
    send_pixel(8'h7f, 8'h7f, 8'h7f);
  endtask

  // Pure primaries, every two-way tie for the maximum, and red-led pixels just
  // either side of zero hue; the negative hues must wrap below 360 degrees.
  task automatic test_primaries_and_ties();
    send_pixel(8'hff, 8'h00, 8'h00);
    send_pixel(8'h00, 8'hff, 8'h00);
    send_pixel(8'h00, 8'h00, 8'hff);
    send_pixel(8'hff, 8'hff, 8'h00);
    send_pixel(8'hff, 8'h00, 8'hff);
    send_pixel(8'h00, 8'hff, 8'hff);
    send_pixel(8'hff, 8'h00, 8'h01);
    send_pixel(8'hff, 8'h01, 8'h00);
    send_pixel(8'h80, 8'h10, 8'h7f);
  endtask

  // Smallest nonzero channels, a one-step spread at full scale, and
  // alternating bit patterns.
  task automatic test_channel_extremes();
    send_pixel(8'h01, 8'h00, 8'h00);
    send_pixel(8'h00, 8'h01, 8'h00);
    send_pixel(8'h00, 8'h00, 8'h01);
    send_pixel(8'hff, 8'hfe, 8'hfe);
    send_pixel(8'hfe, 8'hff, 8'hfe);
    send_pixel(8'hfe, 8'hfe, 8'hff);
    send_pixel(8'haa, 8'h55, 8'hcc);
    send_pixel(8'h55, 8'haa, 8'h33);
  endtask

  // Random pixels, weighted toward greys, ties, near-greys and wrapped hues.
  task automatic test_random_pixels(input int unsigned count);
    int unsigned kind, top, other, base;
    logic [7:0]  r, g, b;
    repeat (count) begin
      kind = $urandom_range(0, 99);
      if (kind < 50) begin
        r = 8'($urandom);
        g = 8'($urandom);
        b = 8'($urandom);
      end else if (kind < 62) begin
        r = 8'($urandom);
        g = r;
        b = r;
      end else if (kind < 77) begin
        top   = $urandom_range(1, 255);
        other = $urandom_range(0, top - 1);
        case ($urandom_range(0, 2))
          0: begin r = 8'(top); g = 8'(top); b = 8'(other); end
          1: begin r = 8'(top); g = 8'(other); b = 8'(top); end
          default: begin r = 8'(other); g = 8'(top); b = 8'(top); end
        endcase
      end else if (kind < 90) begin
        base = $urandom_range(0, 250);
        r = 8'(base + $urandom_range(0, 5));
        g = 8'(base + $urandom_range(0, 5));
        b = 8'(base + $urandom_range(0, 5));
      end else begin
        r = 8'($urandom_range(2, 255));
        g = 8'($urandom_range(0, r - 2));
        b = 8'($urandom_range(g + 1, r));
      end
      send_pixel(r, g, b);
    end
  endtask

  // The receiver holds off while the sender keeps offering, so the pipeline
  // fills and the block must stall its input without losing a request.
  task automatic test_output_backpressure();
    sender_steady = 1'b1;
    hold_request  = 1'b1;
    test_random_pixels(48);
    sender_steady = 1'b0;
    wait_drained();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_grey_and_black();
    test_primaries_and_ties();
    test_channel_extremes();
    wait_drained();
    test_random_pixels(180);
    test_output_backpressure();
    test_random_pixels(180);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (pending_hsv.size() != 0) begin
      report_mismatch("results never returned", 0, pending_hsv.size());
    end
    $display("pixels: %0d sent, %0d results checked, %0d grey or black, %0d tied maxima",
             pixels_accepted, results_checked, grey_pixels, tied_pixels);
    $display("wrapped hues: %0d, input stall cycles under backpressure: %0d",
             wrapped_hues, input_stalls);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
